// ----- sv/qrs_pkg.sv -----
package qrs_pkg;

  // Default coefficient width and fixed-point fraction width
  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // Width of each root value on the result channel
  localparam int OUT_WIDTH = 35;

  // Root classification codes
  typedef enum logic [1:0] {
    KIND_INVALID  = 2'd0,
    KIND_EQUAL    = 2'd1,
    KIND_DISTINCT = 2'd2,
    KIND_COMPLEX  = 2'd3
  } root_kind_t;

endpackage

// ----- sv/qrs_coef_if.sv -----
interface qrs_coef_if #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

// ----- sv/qrs_root_if.sv -----
interface qrs_root_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           root_kind;
  logic signed [qrs_pkg::OUT_WIDTH-1:0] first_value;
  logic signed [qrs_pkg::OUT_WIDTH-1:0] second_value;

  modport source (output valid, root_kind, first_value, second_value, input ready);
  modport sink   (input valid, root_kind, first_value, second_value, output ready);
endinterface

// ----- sv/qrs_sqrt_cell.sv -----
// One digit of a restoring square root: brings down two radicand bits and
// decides one root bit.
module qrs_sqrt_cell #(
  parameter int SW = 33
) (
  input  logic            clk,
  input  logic            en,
  input  logic [SW+2:0]   r_in,
  input  logic [SW-1:0]   s_in,
  input  logic [2*SW-1:0] v_in,
  output logic [SW+2:0]   r_out,
  output logic [SW-1:0]   s_out,
  output logic [2*SW-1:0] v_out
);

  logic [SW+2:0] r_sh;
  logic [SW+2:0] trial;
  logic          fits;

  // Partial remainder against trial value 4s+1
  always_comb begin
    r_sh  = {r_in[SW:0], v_in[2*SW-1 -: 2]};
    trial = (SW+3)'({s_in, 2'b01});
    fits  = (r_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_out <= fits ? (r_sh - trial) : r_sh;
      s_out <= {s_in[SW-2:0], fits};
      v_out <= {v_in[2*SW-3:0], 2'b00};
    end
  end

endmodule

// ----- sv/qrs_div_cell.sv -----
// One quotient bit of a restoring unsigned division. The dividend shifts
// out at the top while quotient bits shift in at the bottom.
module qrs_div_cell #(
  parameter int NW  = 35,
  parameter int DVW = 17
) (
  input  logic           clk,
  input  logic           en,
  input  logic [DVW-1:0] dm,
  input  logic [DVW-1:0] rem_in,
  input  logic [NW-1:0]  nq_in,
  output logic [DVW-1:0] rem_out,
  output logic [NW-1:0]  nq_out
);

  logic [DVW:0] rem_sh;
  logic [DVW:0] diff;
  logic         fits;

  always_comb begin
    rem_sh = {rem_in, nq_in[NW-1]};
    diff   = rem_sh - {1'b0, dm};
    fits   = (rem_sh >= {1'b0, dm});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= fits ? diff[DVW-1:0] : rem_sh[DVW-1:0];
      nq_out  <= {nq_in[NW-2:0], fits};
    end
  end

endmodule

// ----- sv/quadratic_root_solver_unit.sv -----
// Pipeline: 3 front stages, one square-root cell per root bit, one numerator
// stage, one divider cell per quotient bit and one output stage.
// Throughput: one coefficient set per cycle; the whole cell chain advances
// together and holds while a finished result waits for its transfer.
// Reset clears the stage valid flags only; data registers are not reset.
module quadratic_root_solver_unit #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  qrs_coef_if.sink    coefs,
  qrs_root_if.source  roots
);
  import qrs_pkg::*;

  localparam int CW  = COEF_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int OW  = OUT_WIDTH;
  localparam int DMW = 2*CW + 2;
  localparam int VW  = DMW + 2*F;
  localparam int SW  = (VW + 1) / 2;
  localparam int VP  = 2*SW;
  localparam int BW  = CW + F + 1;
  localparam int NW  = ((BW > SW + 1) ? BW : SW + 1) + 1;
  localparam int DVW = CW + 1;
  localparam int SVW = ((NW + 1 > OW) ? NW + 1 : OW) + 1;
  localparam int L   = 5 + SW + NW;

  typedef struct packed {
    root_kind_t           kind;
    logic signed [BW-1:0] bs;
    logic                 den_neg;
    logic [DVW-1:0]       dm;
  } sq_side_t;

  typedef struct packed {
    root_kind_t     kind;
    logic           neg1;
    logic           neg2;
    logic [DVW-1:0] dm;
  } dv_side_t;

  logic [L-1:0] vld;
  logic         en;
  logic         acc;

  assign en          = !vld[L-1] || roots.ready;
  assign coefs.ready = en;
  assign acc         = coefs.valid && en;

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], acc};
    end
  end

  // Front stages: input register, products, discriminant
  logic signed [CW-1:0]   a0, b0, c0, a1, b1;
  logic signed [2*CW-1:0] bb1, ac1;
  logic signed [2*CW+2:0] d_c;
  logic [DMW-1:0]         dmag_c;
  root_kind_t             kind_c;
  logic signed [BW-1:0]   bneg_c;
  logic [CW-1:0]          amag_c;

  always_comb begin
    d_c    = (2*CW+3)'(bb1) - ((2*CW+3)'(ac1) <<< 2);
    dmag_c = d_c[2*CW+2] ? DMW'(-d_c) : DMW'(d_c);
    if (a1 == '0) begin
      kind_c = KIND_INVALID;
    end else if (d_c == '0) begin
      kind_c = KIND_EQUAL;
    end else if (!d_c[2*CW+2]) begin
      kind_c = KIND_DISTINCT;
    end else begin
      kind_c = KIND_COMPLEX;
    end
    bneg_c = -(BW'(b1));
    amag_c = a1[CW-1] ? CW'(-a1) : CW'(a1);
  end

  sq_side_t               sq_side [SW+1];
  logic [SW+2:0]          sq_r    [SW+1];
  logic [SW-1:0]          sq_s    [SW+1];
  logic [VP-1:0]          sq_v    [SW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      a0  <= coefs.coef_a;
      b0  <= coefs.coef_b;
      c0  <= coefs.coef_c;
      bb1 <= b0 * b0;
      ac1 <= a0 * c0;
      a1  <= a0;
      b1  <= b0;
      sq_side[0].kind    <= kind_c;
      sq_side[0].bs      <= bneg_c <<< F;
      sq_side[0].den_neg <= a1[CW-1];
      sq_side[0].dm      <= {amag_c, 1'b0};
      sq_r[0]            <= '0;
      sq_s[0]            <= '0;
      sq_v[0]            <= VP'(dmag_c) << (2*F);
    end
  end

  // Square-root cell chain
  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    qrs_sqrt_cell #(.SW(SW)) u_cell (
      .clk   (clk),
      .en    (en),
      .r_in  (sq_r[k]),
      .s_in  (sq_s[k]),
      .v_in  (sq_v[k]),
      .r_out (sq_r[k+1]),
      .s_out (sq_s[k+1]),
      .v_out (sq_v[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        sq_side[k+1] <= sq_side[k];
      end
    end
  end

  // Numerator stage: form dividends and result signs
  logic signed [NW-1:0] bsx_c, sx_c, n1_c, n2_c;
  sq_side_t             sqo;

  always_comb begin
    sqo   = sq_side[SW];
    bsx_c = NW'(sqo.bs);
    sx_c  = $signed(NW'(sq_s[SW]));
    case (sqo.kind)
      KIND_DISTINCT: begin
        n1_c = bsx_c + sx_c;
        n2_c = bsx_c - sx_c;
      end
      KIND_COMPLEX: begin
        n1_c = bsx_c;
        n2_c = sx_c;
      end
      default: begin
        n1_c = bsx_c;
        n2_c = bsx_c;
      end
    endcase
  end

  dv_side_t       dv_side [NW+1];
  logic [DVW-1:0] rem1    [NW+1];
  logic [DVW-1:0] rem2    [NW+1];
  logic [NW-1:0]  nq1     [NW+1];
  logic [NW-1:0]  nq2     [NW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side[0].kind <= sqo.kind;
      dv_side[0].neg1 <= n1_c[NW-1] ^ sqo.den_neg;
      dv_side[0].neg2 <= n2_c[NW-1] ^ sqo.den_neg;
      dv_side[0].dm   <= sqo.dm;
      rem1[0]         <= '0;
      rem2[0]         <= '0;
      nq1[0]          <= n1_c[NW-1] ? NW'(-n1_c) : NW'(n1_c);
      nq2[0]          <= n2_c[NW-1] ? NW'(-n2_c) : NW'(n2_c);
    end
  end

  // Divider cell chain, two lanes side by side
  for (genvar j = 0; j < NW; j++) begin : g_div
    qrs_div_cell #(.NW(NW), .DVW(DVW)) u_lane1 (
      .clk     (clk),
      .en      (en),
      .dm      (dv_side[j].dm),
      .rem_in  (rem1[j]),
      .nq_in   (nq1[j]),
      .rem_out (rem1[j+1]),
      .nq_out  (nq1[j+1])
    );
    qrs_div_cell #(.NW(NW), .DVW(DVW)) u_lane2 (
      .clk     (clk),
      .en      (en),
      .dm      (dv_side[j].dm),
      .rem_in  (rem2[j]),
      .nq_in   (nq2[j]),
      .rem_out (rem2[j+1]),
      .nq_out  (nq2[j+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        dv_side[j+1] <= dv_side[j];
      end
    end
  end

  // Output stage: restore sign and saturate; an invalid set gives zero roots
  function automatic logic signed [OW-1:0] sat_out(input logic [NW-1:0] q,
                                                    input logic neg);
    logic signed [SVW-1:0] v;
    logic signed [SVW-1:0] hi;
    logic signed [SVW-1:0] lo;
    v  = $signed(SVW'(q));
    v  = neg ? -v : v;
    hi = $signed((SVW'(1) << (OW-1)) - SVW'(1));
    lo = -hi - SVW'(1);
    if (v > hi) begin
      v = hi;
    end else if (v < lo) begin
      v = lo;
    end
    return v[OW-1:0];
  endfunction

  dv_side_t dvo;
  assign dvo = dv_side[NW];

  always_ff @(posedge clk) begin
    if (en) begin
      roots.root_kind <= dvo.kind;
      if (dvo.kind == KIND_INVALID) begin
        roots.first_value  <= '0;
        roots.second_value <= '0;
      end else begin
        roots.first_value  <= sat_out(nq1[NW], dvo.neg1);
        roots.second_value <= sat_out(nq2[NW], dvo.neg2);
      end
    end
  end

  assign roots.valid = vld[L-1];

endmodule

// ----- tb/quadratic_root_solver_unit_tb.sv -----
`timescale 1ns / 1ps

module quadratic_root_solver_unit_tb;
  import qrs_pkg::*;

  localparam int CW   = COEF_WIDTH_DEF;
  localparam int FB   = FRAC_BITS_DEF;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    root_kind_t                  kind;
    logic signed [OUT_WIDTH-1:0] first_v;
    logic signed [OUT_WIDTH-1:0] second_v;
  } roots_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qrs_coef_if #(.COEF_WIDTH(CW)) coefs ();
  qrs_root_if                    roots ();

  quadratic_root_solver_unit dut (
    .clk   (clk),
    .rst   (rst),
    .coefs (coefs.sink),
    .roots (roots.source)
  );

  roots_t pending_roots[$];
  int     errors     = 0;
  int     cycles     = 0;
  int     send_idle  = 0;
  int     recv_idle  = 0;
  int     hold_count = 0;

  always #2 clk = ~clk;

  // Clamp to the signed output range
  function automatic logic signed [OUT_WIDTH-1:0] clamp_out(longint v);
    longint hi;
    hi = (longint'(1) <<< (OUT_WIDTH - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v[OUT_WIDTH-1:0];
  endfunction

  // Roots of a*x^2 + b*x + c in fixed point
  function automatic roots_t solve_roots(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                                         logic signed [CW-1:0] c);
    roots_t      res;
    longint      sa, sb, sc, disc, den, bs, s;
    logic [127:0] rad, rem, trial, sq;
    sa = a;
    sb = b;
    sc = c;
    res.kind     = KIND_INVALID;
    res.first_v  = '0;
    res.second_v = '0;
    if (sa == 0) return res;
    disc = sb * sb - 4 * sa * sc;
    rad  = (disc < 0) ? 128'(-disc) : 128'(disc);
    rad  = rad << (2 * FB);
    // bitwise integer square root, two radicand bits per step
    rem = '0;
    sq  = '0;
    for (int p = 126; p >= 0; p -= 2) begin
      rem   = (rem << 2) | ((rad >> p) & 128'd3);
      trial = (sq << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        sq  = (sq << 1) | 128'd1;
      end else begin
        sq = sq << 1;
      end
    end
    s   = longint'(sq[62:0]);
    den = 2 * sa;
    bs  = -sb * (longint'(1) <<< FB);
    if (disc == 0) begin
      res.kind     = KIND_EQUAL;
      res.first_v  = clamp_out(bs / den);
      res.second_v = res.first_v;
    end else if (disc > 0) begin
      res.kind     = KIND_DISTINCT;
      res.first_v  = clamp_out((bs + s) / den);
      res.second_v = clamp_out((bs - s) / den);
    end else begin
      res.kind     = KIND_COMPLEX;
      res.first_v  = clamp_out(bs / den);
      res.second_v = clamp_out(s / den);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  // Predict on each input transfer, check on each result transfer
  always @(posedge clk) begin
    roots_t want;
    if (!rst) begin
      if (roots.valid && roots.ready) begin
        if (pending_roots.size() == 0) begin
          report_mismatch("result with nothing pending");
        end else begin
          want = pending_roots.pop_front();
          if (roots.root_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", roots.root_kind, want.kind));
          if (roots.first_value !== want.first_v)
            report_mismatch($sformatf("first %0d, want %0d", roots.first_value, want.first_v));
          if (roots.second_value !== want.second_v)
            report_mismatch($sformatf("second %0d, want %0d", roots.second_value,
                                      want.second_v));
        end
      end
      if (coefs.valid && coefs.ready)
        pending_roots.push_back(solve_roots(coefs.coef_a, coefs.coef_b, coefs.coef_c));
    end
  end

  // Result side: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (rst) begin
      roots.ready <= 1'b0;
    end else if (hold_count > 0) begin
      roots.ready <= 1'b0;
      hold_count--;
    end else begin
      roots.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("quadratic_root_solver_unit_tb: errors");
      $finish;
    end
  end

  // Offer one coefficient set and wait for its transfer
  task automatic send_coefs(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                            logic signed [CW-1:0] c);
    while ($urandom_range(99) < send_idle) begin
      coefs.valid <= 1'b0;
      @(negedge clk);
    end
    coefs.valid  <= 1'b1;
    coefs.coef_a <= a;
    coefs.coef_b <= b;
    coefs.coef_c <= c;
    @(posedge clk);
    while (!coefs.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    coefs.valid <= 1'b0;
    while (pending_roots.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    send_coefs(16'sd0, 16'sd5, -16'sd3);
    send_coefs(16'sd0, -16'sd32768, 16'sd32767);
    send_coefs(16'sd1, 16'sd2, 16'sd1);
    send_coefs(-16'sd1, 16'sd2, -16'sd1);
    send_coefs(16'sd4, -16'sd4, 16'sd1);
    send_coefs(16'sd1, -16'sd3, 16'sd2);
    send_coefs(-16'sd2, 16'sd3, 16'sd7);
    send_coefs(16'sd1, 16'sd0, 16'sd1);
    send_coefs(-16'sd1, 16'sd1, -16'sd5);
    send_coefs(16'sd3, 16'sd0, 16'sd0);
    send_coefs(16'sd32767, 16'sd32767, 16'sd32767);
    send_coefs(-16'sd32768, -16'sd32768, -16'sd32768);
    send_coefs(-16'sd32768, 16'sd32767, 16'sd32767);
    send_coefs(16'sd32767, -16'sd32768, -16'sd32768);
    send_coefs(16'sd1, -16'sd32768, 16'sd0);
    send_coefs(16'sd1, 16'sd32767, -16'sd32768);
    send_coefs(-16'sd1, 16'sd0, 16'sd0);
    send_coefs(16'sd7, 16'sd1, -16'sd1);
    send_coefs(-16'sd32768, 16'sd0, 16'sd32767);
    wait_drained();
  endtask

  // Random sets: perfect squares, small values, sets with a zero and full-range sets
  task automatic test_random(int count);
    int a, r, sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(9);
      if (sel < 3) begin
        a = $urandom_range(16) - 8;
        if (a == 0) a = 1;
        r = $urandom_range(40) - 20;
        send_coefs(CW'(a), CW'(-2 * a * r), CW'(a * r * r));
      end else if (sel < 5) begin
        send_coefs(CW'($urandom_range(20) - 10), CW'($urandom_range(40) - 20),
                   CW'($urandom_range(40) - 20));
      end else if (sel == 5) begin
        send_coefs('0, CW'($urandom), CW'($urandom));
      end else begin
        send_coefs(CW'($urandom), CW'($urandom), CW'($urandom));
      end
    end
    wait_drained();
  endtask

  // Long result hold-off while sets keep coming, then pause until drained
  task automatic test_backpressure();
    hold_count = 300;
    test_random(120);
  endtask

  initial begin
    coefs.valid  = 1'b0;
    coefs.coef_a = '0;
    coefs.coef_b = '0;
    coefs.coef_c = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    send_idle = 32;
    recv_idle = 60;
    test_random(170);
    send_idle = 60;
    recv_idle = 32;
    test_random(170);
    send_idle = 0;
    recv_idle = 0;
    test_random(170);
    test_backpressure();

    repeat (150) @(posedge clk);
    if (errors == 0 && pending_roots.size() == 0) begin
      $display("quadratic_root_solver_unit_tb: clean");
    end else begin
      $display("quadratic_root_solver_unit_tb: errors");
    end
    $finish;
  end

endmodule
